// File: sv/s2q_pkg.sv
// Shared types, constants and codes for the two-queue page replacement block.
package s2q_pkg;

	localparam int NUM_FRAMES    = 256;
	localparam int LIMIT_DIVISOR = 10;
	localparam int FRAME_W       = $clog2(NUM_FRAMES);
	localparam int CNT_W         = $clog2(NUM_FRAMES + 1);
	localparam int SUM_W         = CNT_W + 1;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_LIMIT_ADDR = APB_ADDR_W'(0);
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(NUM_FRAMES / LIMIT_DIVISOR);

	// Request and status codes
	localparam logic REQ_REF      = 1'b0;
	localparam logic REQ_EVICT    = 1'b1;
	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		TAG_NONE   = 2'd0,
		TAG_RECENT = 2'd1,
		TAG_MAIN   = 2'd2
	} tag_t;

	typedef enum logic {
		Q_RECENT = 1'b0,
		Q_MAIN   = 1'b1
	} qsel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_PUSH1,
		ST_PUSH2,
		ST_DONE
	} state_t;

	// Write requests into the link and tag memories
	typedef struct packed {
		logic   nxt_we;
		frame_t nxt_addr;
		frame_t nxt_data;
		logic   prv_we;
		frame_t prv_addr;
		frame_t prv_data;
		logic   tag_we;
		frame_t tag_addr;
		tag_t   tag_data;
	} link_wr_t;

	// Registered read data of one frame
	typedef struct packed {
		tag_t   tag;
		frame_t nxt;
		frame_t prv;
	} link_rd_t;

endpackage

// File: sv/s2q_link_store.sv
// Link and membership memories: next/prev links and queue tags per frame.
module s2q_link_store (
	input  logic                clk,
	input  logic                arst_n,
	input  s2q_pkg::frame_t     rd_addr,
	input  s2q_pkg::link_wr_t   wr,
	output s2q_pkg::link_rd_t   rd
);

	s2q_pkg::frame_t next_mem [s2q_pkg::NUM_FRAMES];
	s2q_pkg::frame_t prev_mem [s2q_pkg::NUM_FRAMES];
	s2q_pkg::tag_t   tag_mem  [s2q_pkg::NUM_FRAMES];
	logic [s2q_pkg::NUM_FRAMES-1:0] tag_vld_q;

	s2q_pkg::frame_t next_rd_q;
	s2q_pkg::frame_t prev_rd_q;
	s2q_pkg::tag_t   tag_rd_q;
	logic            vld_rd_q;

	// Write and read the link memories
	always_ff @(posedge clk) begin
		if (wr.nxt_we) begin
			next_mem[wr.nxt_addr] <= wr.nxt_data;
		end
		if (wr.prv_we) begin
			prev_mem[wr.prv_addr] <= wr.prv_data;
		end
		if (wr.tag_we) begin
			tag_mem[wr.tag_addr] <= wr.tag_data;
		end
		next_rd_q <= next_mem[rd_addr];
		prev_rd_q <= prev_mem[rd_addr];
		tag_rd_q  <= tag_mem[rd_addr];
	end

	// Mark tag entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_q <= '0;
			vld_rd_q  <= 1'b0;
		end else begin
			if (wr.tag_we) begin
				tag_vld_q[wr.tag_addr] <= 1'b1;
			end
			vld_rd_q <= tag_vld_q[rd_addr];
		end
	end

	// Unwritten tags read as no queue
	always_comb begin
		rd.tag = vld_rd_q ? tag_rd_q : s2q_pkg::TAG_NONE;
		rd.nxt = next_rd_q;
		rd.prv = prev_rd_q;
	end

endmodule

// File: sv/simplified_2q_page_replacement_top.sv
// Top level of the two-queue page replacement block: sequencer, queue registers, ports.
//
// Use: each input transfer on the s_ group is one request. s_tuser is the request type
// (0 = reference a frame, 1 = ask for an eviction victim), s_tdata the frame number.
// Every request answers with exactly one transfer on the m_ group: m_tdata is the victim
// frame (zero for references and for empty queues), m_tuser the status (1 = eviction
// asked while both queues are empty). The APB port writes and reads the recent-queue
// limit at address 0.
// Steps: a reference passes ST_LOOK (tag/link read, unlink), then ST_PUSH1 and ST_PUSH2 (two
// head-insert writes) before the next accept; an eviction passes ST_LOOK, an empty answer
// ST_DONE. These steps are set by the single write port of each link memory and its
// registered read. The result is loaded into the output register at the end of the last step.
// Reset: both queues empty, all frames untagged, limit = NUM_FRAMES / 10.
// Stall: the output register holds a result while m_tready is low; the block still accepts
// the next request and works on it up to its last step, which waits for the register.
module simplified_2q_page_replacement_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [s2q_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [s2q_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [s2q_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	// Request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] frame_index
	input  logic [0:0]                         s_tuser,   // [0] req_type
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // [7:0] victim_frame
	output logic [0:0]                         m_tuser    // [0] status
);

	s2q_pkg::state_t  state_q, state_d;
	logic             req_q;
	s2q_pkg::frame_t  frame_q;
	s2q_pkg::qsel_t   uq_q;
	s2q_pkg::qsel_t   pq_q;
	s2q_pkg::frame_t  head_q [2];
	s2q_pkg::frame_t  tail_q [2];
	s2q_pkg::cnt_t    cnt_q  [2];
	s2q_pkg::cnt_t    limit_q;

	logic             m_tvalid_q;
	s2q_pkg::frame_t  m_tdata_q;
	logic             m_tuser_q;

	s2q_pkg::frame_t  rd_addr;
	s2q_pkg::link_wr_t wr;
	s2q_pkg::link_rd_t rd;

	logic             accept;
	logic             evict_in;
	s2q_pkg::qsel_t   sel;
	logic             have;
	logic             out_free;
	logic             out_load;
	s2q_pkg::frame_t  out_victim;
	logic             out_status;
	s2q_pkg::qsel_t   uq;
	logic             do_unlink;
	logic             is_head;
	logic             is_tail;
	logic             cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == s2q_pkg::REG_LIMIT_ADDR);
	assign prdata = (paddr == s2q_pkg::REG_LIMIT_ADDR) ?
		s2q_pkg::APB_DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= s2q_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[s2q_pkg::CNT_W-1:0];
		end
	end

	// Pick the victim queue from the current lengths
	assign evict_in = (s_tuser[0] == s2q_pkg::REQ_EVICT);
	always_comb begin
		sel  = s2q_pkg::Q_RECENT;
		have = 1'b1;
		if (cnt_q[s2q_pkg::Q_RECENT] > limit_q) begin
			sel = s2q_pkg::Q_RECENT;
		end else if (cnt_q[s2q_pkg::Q_MAIN] != '0) begin
			sel = s2q_pkg::Q_MAIN;
		end else if (cnt_q[s2q_pkg::Q_RECENT] != '0) begin
			sel = s2q_pkg::Q_RECENT;
		end else begin
			have = 1'b0;
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Read the referenced frame or the victim at accept, else hold the frame
	always_comb begin
		if (state_q == s2q_pkg::ST_IDLE) begin
			rd_addr = evict_in ? tail_q[sel] : s_tdata;
		end else begin
			rd_addr = frame_q;
		end
	end

	// Unlink target compare
	assign uq = req_q ? uq_q : ((rd.tag == s2q_pkg::TAG_MAIN) ? s2q_pkg::Q_MAIN : s2q_pkg::Q_RECENT);
	assign is_head = (frame_q == head_q[uq]);
	assign is_tail = (frame_q == tail_q[uq]);

	s2q_link_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

	// Sequencer: next state, memory writes, result load
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		wr         = '0;
		do_unlink  = 1'b0;
		out_load   = 1'b0;
		out_victim = '0;
		out_status = s2q_pkg::STATUS_DONE;
		case (state_q)
			s2q_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (evict_in && !have) ? s2q_pkg::ST_DONE : s2q_pkg::ST_LOOK;
				end
			end
			s2q_pkg::ST_LOOK: begin
				if (req_q == s2q_pkg::REQ_EVICT) begin
					if (out_free) begin
						do_unlink   = 1'b1;
						wr.tag_we   = 1'b1;
						wr.tag_addr = frame_q;
						wr.tag_data = s2q_pkg::TAG_NONE;
						out_load    = 1'b1;
						out_victim  = frame_q;
						state_d     = s2q_pkg::ST_IDLE;
					end
				end else begin
					do_unlink = (rd.tag == s2q_pkg::TAG_RECENT) || (rd.tag == s2q_pkg::TAG_MAIN);
					state_d   = s2q_pkg::ST_PUSH1;
				end
				// Bridge the neighbors around the removed frame
				if (do_unlink) begin
					wr.nxt_we   = !is_head;
					wr.nxt_addr = rd.prv;
					wr.nxt_data = rd.nxt;
					wr.prv_we   = !is_tail;
					wr.prv_addr = rd.nxt;
					wr.prv_data = rd.prv;
				end
			end
			s2q_pkg::ST_PUSH1: begin
				wr.nxt_we   = 1'b1;
				wr.nxt_addr = frame_q;
				wr.tag_we   = 1'b1;
				wr.tag_addr = frame_q;
				wr.tag_data = (pq_q == s2q_pkg::Q_RECENT) ? s2q_pkg::TAG_RECENT : s2q_pkg::TAG_MAIN;
				if (cnt_q[pq_q] == '0) begin
					wr.nxt_data = frame_q;
				end else begin
					wr.nxt_data = head_q[pq_q];
					wr.prv_we   = 1'b1;
					wr.prv_addr = head_q[pq_q];
					wr.prv_data = frame_q;
				end
				state_d = s2q_pkg::ST_PUSH2;
			end
			s2q_pkg::ST_PUSH2: begin
				if (out_free) begin
					wr.prv_we   = 1'b1;
					wr.prv_addr = frame_q;
					wr.prv_data = frame_q;
					out_load    = 1'b1;
					state_d     = s2q_pkg::ST_IDLE;
				end
			end
			s2q_pkg::ST_DONE: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = s2q_pkg::STATUS_EMPTY;
					state_d    = s2q_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = s2q_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s2q_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the request at accept and the push queue in ST_LOOK
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_tuser[0];
			frame_q <= evict_in ? tail_q[sel] : s_tdata;
			uq_q    <= sel;
		end
		if (state_q == s2q_pkg::ST_LOOK) begin
			pq_q <= ((rd.tag == s2q_pkg::TAG_RECENT) || (rd.tag == s2q_pkg::TAG_MAIN)) ?
				s2q_pkg::Q_MAIN : s2q_pkg::Q_RECENT;
		end
	end

	// Queue heads, tails and lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (do_unlink) begin
				if (is_head) begin
					head_q[uq] <= rd.nxt;
				end
				if (is_tail) begin
					tail_q[uq] <= rd.prv;
				end
				if (cnt_q[uq] != '0) begin
					cnt_q[uq] <= cnt_q[uq] - s2q_pkg::CNT_W'(1);
				end
			end
			if (state_q == s2q_pkg::ST_PUSH1 && cnt_q[pq_q] == '0) begin
				tail_q[pq_q] <= frame_q;
			end
			if (state_q == s2q_pkg::ST_PUSH2 && out_free) begin
				head_q[pq_q] <= frame_q;
				cnt_q[pq_q]  <= cnt_q[pq_q] + s2q_pkg::CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_victim;
			m_tuser_q <= out_status;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// Both queues together never hold more frames than exist
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(s2q_pkg::SUM_W'(cnt_q[s2q_pkg::Q_RECENT]) + s2q_pkg::SUM_W'(cnt_q[s2q_pkg::Q_MAIN]))
			<= s2q_pkg::SUM_W'(s2q_pkg::NUM_FRAMES))
		else $error("queue lengths exceed frame count");

	// A result is loaded only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending result");

	// An eviction victim carries the tag of the queue it leaves
	a_victim_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2q_pkg::ST_LOOK && req_q == s2q_pkg::REQ_EVICT) |->
			((uq_q == s2q_pkg::Q_RECENT && rd.tag == s2q_pkg::TAG_RECENT) ||
			 (uq_q == s2q_pkg::Q_MAIN && rd.tag == s2q_pkg::TAG_MAIN)))
		else $error("victim not tagged for its queue");

	// An eviction is never taken from an empty queue
	a_victim_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2q_pkg::ST_LOOK && req_q == s2q_pkg::REQ_EVICT) |-> (cnt_q[uq_q] != '0))
		else $error("eviction from an empty queue");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the two-queue page replacement block.
`timescale 1ns / 100ps

module testbench;

	// One expected answer on the result stream
	typedef struct packed {
		s2q_pkg::frame_t victim;
		logic            status;
	} answer_t;

	// Tracks both queues and the answers still owed by the block
	class replacement_tracker;
		s2q_pkg::cnt_t   recent_limit;
		s2q_pkg::tag_t   tags[s2q_pkg::NUM_FRAMES];
		s2q_pkg::frame_t toward_tail[s2q_pkg::NUM_FRAMES];
		s2q_pkg::frame_t toward_head[s2q_pkg::NUM_FRAMES];
		s2q_pkg::frame_t heads[2];
		s2q_pkg::frame_t tails[2];
		s2q_pkg::cnt_t   lengths[2];
		answer_t         answers[$];
		int              errors;

		function new();
			recent_limit = s2q_pkg::LIMIT_RESET;
			foreach (tags[i]) begin
				tags[i] = s2q_pkg::TAG_NONE;
				toward_tail[i] = '0;
				toward_head[i] = '0;
			end
			foreach (heads[i]) begin
				heads[i] = '0;
				tails[i] = '0;
				lengths[i] = '0;
			end
			errors = 0;
		endfunction

		// Take a frame out of its queue and untag it
		function void drop(s2q_pkg::qsel_t q, s2q_pkg::frame_t f);
			s2q_pkg::frame_t p, n;
			p = toward_head[f];
			n = toward_tail[f];
			if (f == heads[q]) begin
				heads[q] = n;
			end else begin
				toward_tail[p] = n;
			end
			if (f == tails[q]) begin
				tails[q] = p;
			end else begin
				toward_head[n] = p;
			end
			if (lengths[q] != 0)
				lengths[q] = lengths[q] - 1'b1;
			tags[f] = s2q_pkg::TAG_NONE;
		endfunction

		// Insert a frame at the most recent end of a queue
		function void push_front(s2q_pkg::qsel_t q, s2q_pkg::frame_t f);
			if (lengths[q] == 0) begin
				tails[q] = f;
				toward_tail[f] = f;
			end else begin
				toward_head[heads[q]] = f;
				toward_tail[f] = heads[q];
			end
			toward_head[f] = f;
			heads[q] = f;
			lengths[q] = lengths[q] + 1'b1;
			if (q == s2q_pkg::Q_RECENT) begin
				tags[f] = s2q_pkg::TAG_RECENT;
			end else begin
				tags[f] = s2q_pkg::TAG_MAIN;
			end
		endfunction

		// Apply one accepted request and queue the answer it owes
		function void note_request(logic req, s2q_pkg::frame_t frame);
			answer_t        a;
			s2q_pkg::qsel_t q;
			bit             have;
			a.victim = '0;
			a.status = s2q_pkg::STATUS_DONE;
			if (req == s2q_pkg::REQ_REF) begin
				case (tags[frame])
				s2q_pkg::TAG_RECENT: begin
					drop(s2q_pkg::Q_RECENT, frame);
					push_front(s2q_pkg::Q_MAIN, frame);
				end
				s2q_pkg::TAG_MAIN: begin
					drop(s2q_pkg::Q_MAIN, frame);
					push_front(s2q_pkg::Q_MAIN, frame);
				end
				default: push_front(s2q_pkg::Q_RECENT, frame);
				endcase
			end else begin
				have = 1'b1;
				q = s2q_pkg::Q_RECENT;
				if (lengths[s2q_pkg::Q_RECENT] > recent_limit)
					q = s2q_pkg::Q_RECENT;
				else if (lengths[s2q_pkg::Q_MAIN] != 0)
					q = s2q_pkg::Q_MAIN;
				else if (lengths[s2q_pkg::Q_RECENT] == 0)
					have = 1'b0;
				if (have) begin
					a.victim = tails[q];
					drop(q, a.victim);
				end else begin
					a.status = s2q_pkg::STATUS_EMPTY;
				end
			end
			answers.push_back(a);
		endfunction

		// Compare one result transfer with the oldest owed answer
		function void check_answer(s2q_pkg::frame_t victim, logic status);
			answer_t a;
			if (answers.size() == 0) begin
				$error("unexpected result: victim_frame %0d status %0d", victim, status);
				errors++;
				return;
			end
			a = answers.pop_front();
			if (victim !== a.victim) begin
				$error("victim_frame: expected %0d, got %0d", a.victim, victim);
				errors++;
			end
			if (status !== a.status) begin
				$error("status: expected %0d, got %0d", a.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [s2q_pkg::APB_ADDR_W-1:0] paddr;
	logic [s2q_pkg::APB_DATA_W-1:0] pwdata;
	logic [s2q_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;   // [7:0] frame_index
	logic [0:0]                     s_tuser;   // [0] req_type
	logic                           m_tvalid;
	logic                           m_tready;
	logic [7:0]                     m_tdata;   // [7:0] victim_frame
	logic [0:0]                     m_tuser;   // [0] status

	replacement_tracker tracker = new();
	int burst_left = 0;
	bit hold_out = 1'b0;

	simplified_2q_page_replacement_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Note accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_request(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_answer(m_tdata, m_tuser[0]);
		end
	end

	// Result side: stall in changing patterns, hold off for a long stretch on request
	initial begin
		int mode;
		int left;
		m_tready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 80);
				end
				left--;
				case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Offer one request; bursts of random length, with a random idle gap or none between them
	task automatic offer_request(input logic req, input s2q_pkg::frame_t frame);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= frame;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and let every owed answer arrive
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		// Let the last accepted request be noted before counting what is owed
		@(posedge clk);
		while (tracker.answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the recent-queue limit, then read it back
	task automatic write_limit(input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= s2q_pkg::REG_LIMIT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.recent_limit = s2q_pkg::cnt_t'(value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== s2q_pkg::APB_DATA_W'(tracker.recent_limit)) begin
			$error("recent_queue_limit: expected %0d, got %0d", tracker.recent_limit, prdata);
			tracker.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stimulus
	initial begin
		int unsigned limits[6];
		int pools[6];
		int pool;
		int evict_pct;
		int unsigned base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty answer, fill recent, promote, main hit, main-empty fallback
		offer_request(s2q_pkg::REQ_EVICT, 8'hFF);
		offer_request(s2q_pkg::REQ_REF, 8'h00);
		offer_request(s2q_pkg::REQ_REF, 8'hFF);
		offer_request(s2q_pkg::REQ_REF, 8'h55);
		offer_request(s2q_pkg::REQ_REF, 8'hAA);
		offer_request(s2q_pkg::REQ_REF, 8'hFF);
		offer_request(s2q_pkg::REQ_REF, 8'hFF);
		offer_request(s2q_pkg::REQ_REF, 8'h55);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		offer_request(s2q_pkg::REQ_EVICT, 8'hAA);
		offer_request(s2q_pkg::REQ_EVICT, 8'h55);
		offer_request(s2q_pkg::REQ_EVICT, 8'h12);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		wait_idle();

		// Directed: zero limit makes the recent queue supply victims first
		write_limit(0);
		@(posedge clk);
		offer_request(s2q_pkg::REQ_REF, 8'h01);
		offer_request(s2q_pkg::REQ_REF, 8'h02);
		offer_request(s2q_pkg::REQ_REF, 8'h03);
		offer_request(s2q_pkg::REQ_REF, 8'h02);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		offer_request(s2q_pkg::REQ_EVICT, 8'h00);
		wait_idle();

		// Random phases, each with its own limit, frame pool and eviction mix
		limits = '{256, 0, 3, 25, 0, 0};
		limits[4] = $urandom_range(1, 40);
		limits[5] = $urandom_range(0, 256);
		pools = '{16, 256, 8, 32, 64, 0};
		pools[5] = $urandom_range(2, 256);
		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			@(posedge clk);
			pool = pools[p];
			evict_pct = $urandom_range(15, 45);
			base = $urandom_range(0, 255);
			for (int n = 0; n < 192; n++) begin
				if (p == 1 && n == 40)
					hold_out = 1'b1;
				if (p == 3 && n == 96)
					wait_idle();
				if ($urandom_range(0, 99) < evict_pct)
					offer_request(s2q_pkg::REQ_EVICT,
						s2q_pkg::frame_t'($urandom_range(0, 255)));
				else
					offer_request(s2q_pkg::REQ_REF,
						s2q_pkg::frame_t'(base + $urandom_range(0, pool - 1)));
			end
			wait_idle();
		end

		if (tracker.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
